/* rtl/rpeh_pkg.sv */
// Shared types and constants for the rotate-half rotary position embedding unit.
package rpeh_pkg;

  localparam int ValW = 16;   // Q8.8 vector values and Q1.14 table values
  localparam int IdxW = 8;    // element index on the result channel
  localparam int CfgW = 8;    // half_dim register width
  localparam logic [CfgW-1:0] HalfDimReset = 8'd32;

  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);

  localparam int ProdW = 2 * ValW;
  localparam int SumW  = ProdW + 1;
  localparam int RndShift = 14;
  localparam logic signed [SumW-1:0] RndBias = SumW'(8192);

  // One pairing of a stored first-half element with a second-half element.
  typedef struct packed {
    logic signed [ValW-1:0] a_val;   // stored element d
    logic signed [ValW-1:0] a_cos;
    logic signed [ValW-1:0] a_sin;
    logic signed [ValW-1:0] x_val;   // incoming element d+h
    logic signed [ValW-1:0] x_cos;
    logic signed [ValW-1:0] x_sin;
    logic [IdxW-1:0]        idx_lo;
    logic [IdxW-1:0]        idx_hi;
    logic                   vend;
  } job_t;

endpackage

/* rtl/rpeh_front.sv */
// Front end: half_dim register, element counter, first-half store and job issue.
module rpeh_front #(
  parameter int MAX_HEAD_DIM = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rpeh_pkg::CfgW-1:0]    cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [rpeh_pkg::ValW-1:0]    x_val_i,
  input  logic [rpeh_pkg::ValW-1:0]    x_cos_i,
  input  logic [rpeh_pkg::ValW-1:0]    x_sin_i,
  output logic                         push_o,
  output rpeh_pkg::job_t               push_data_o,
  input  logic                         q_full_i
);

  localparam int HalfMax = MAX_HEAD_DIM / 2;
  localparam int CntW    = $clog2(MAX_HEAD_DIM);
  localparam int CntXW   = CntW + 1;
  localparam int AddrW   = (HalfMax > 1) ? $clog2(HalfMax) : 1;
  localparam int CmpW    = ((CntW > rpeh_pkg::CfgW) ? CntW : rpeh_pkg::CfgW) + 1;
  localparam int EntW    = 3 * rpeh_pkg::ValW;

  logic [rpeh_pkg::CfgW-1:0] half_dim_q;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic [CmpW-1:0]           h_cmp;
  logic [CntXW-1:0]          h_eff, two_h, n, n_inc, d;
  logic                      first, vend, accept;

  logic [EntW-1:0]           mem [HalfMax];
  logic [EntW-1:0]           rd_q;

  logic                      s1_valid_q;
  logic [rpeh_pkg::ValW-1:0] s1_val_q, s1_cos_q, s1_sin_q;
  logic [rpeh_pkg::IdxW-1:0] s1_lo_q, s1_hi_q;
  logic                      s1_vend_q;

  // Clamp the half length to 1..HalfMax
  always_comb begin
    h_cmp = CmpW'(half_dim_q);
    if (h_cmp == '0) begin
      h_cmp = CmpW'(1);
    end else if (h_cmp > CmpW'(HalfMax)) begin
      h_cmp = CmpW'(HalfMax);
    end
    h_eff = CntXW'(h_cmp);
    two_h = h_eff << 1;
    n     = (CntXW'(cnt_q) >= two_h) ? '0 : CntXW'(cnt_q);
    first = n < h_eff;
    d     = n - h_eff;
    n_inc = n + CntXW'(1);
    vend  = n_inc == two_h;
  end

  assign in_ready_o = !s1_valid_q || !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cnt_d = cnt_q;
    if (cfg_we_i) begin
      cnt_d = '0;
    end else if (accept) begin
      cnt_d = (!first && vend) ? '0 : CntW'(n_inc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_dim_q <= rpeh_pkg::HalfDimReset;
      cnt_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        half_dim_q <= cfg_wdata_i;
      end
      cnt_q <= cnt_d;
      if (in_ready_o) begin
        s1_valid_q <= accept && !first;
      end
    end
  end

  // First-half store: written by first-half transactions, read by second-half ones
  always_ff @(posedge clk_i) begin
    if (accept && first) begin
      mem[n[AddrW-1:0]] <= {x_sin_i, x_cos_i, x_val_i};
    end
    if (accept && !first) begin
      rd_q <= mem[d[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !first) begin
      s1_val_q  <= x_val_i;
      s1_cos_q  <= x_cos_i;
      s1_sin_q  <= x_sin_i;
      s1_lo_q   <= rpeh_pkg::IdxW'(d);
      s1_hi_q   <= rpeh_pkg::IdxW'(n);
      s1_vend_q <= vend;
    end
  end

  assign push_o = s1_valid_q && !q_full_i;

  always_comb begin
    push_data_o.a_val  = rd_q[rpeh_pkg::ValW-1:0];
    push_data_o.a_cos  = rd_q[2*rpeh_pkg::ValW-1:rpeh_pkg::ValW];
    push_data_o.a_sin  = rd_q[EntW-1:2*rpeh_pkg::ValW];
    push_data_o.x_val  = s1_val_q;
    push_data_o.x_cos  = s1_cos_q;
    push_data_o.x_sin  = s1_sin_q;
    push_data_o.idx_lo = s1_lo_q;
    push_data_o.idx_hi = s1_hi_q;
    push_data_o.vend   = s1_vend_q;
  end

  a_cnt_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CntXW'(cnt_q) < two_h)
    else $error("element counter beyond vector length");

endmodule

/* rtl/rpeh_queue.sv */
// Short job queue between the front end and the rotation datapath.
module rpeh_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rpeh_pkg::job_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output rpeh_pkg::job_t data_o
);

  rpeh_pkg::job_t                entries_q [rpeh_pkg::QueueDepth];
  logic [rpeh_pkg::QPtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [rpeh_pkg::QPtrW:0]      count_q;

  assign full_o  = count_q == (rpeh_pkg::QPtrW+1)'(rpeh_pkg::QueueDepth);
  assign valid_o = count_q != '0;
  assign data_o  = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + rpeh_pkg::QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + rpeh_pkg::QPtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (rpeh_pkg::QPtrW+1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (rpeh_pkg::QPtrW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");

endmodule

/* rtl/rpeh_back.sv */
// Back end: two results per job through a product stage and a round/saturate output stage.
module rpeh_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              job_valid_i,
  input  rpeh_pkg::job_t                    job_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [rpeh_pkg::ValW-1:0]  out_value_o,
  output logic [rpeh_pkg::IdxW-1:0]         out_index_o,
  output logic                              out_last_o,
  output logic                              out_vend_o
);

  localparam int QW = rpeh_pkg::SumW - rpeh_pkg::RndShift;

  logic phase_q;
  logic issue, p_ready, o_ready;

  logic                              p_valid_q, p_sub_q, p_last_q, p_vend_q;
  logic signed [rpeh_pkg::ProdW-1:0] p1_q, p2_q;
  logic [rpeh_pkg::IdxW-1:0]         p_idx_q;

  logic signed [rpeh_pkg::ValW-1:0]  m_a, m_b, m_c, m_e;
  logic signed [rpeh_pkg::SumW-1:0]  sum, rnd;
  logic signed [QW-1:0]              qv;
  logic signed [rpeh_pkg::ValW-1:0]  sat;

  logic                              o_valid_q, o_last_q, o_vend_q;
  logic signed [rpeh_pkg::ValW-1:0]  o_value_q;
  logic [rpeh_pkg::IdxW-1:0]         o_index_q;

  assign o_ready = !o_valid_q || out_ready_i;
  assign p_ready = !p_valid_q || o_ready;
  assign issue   = job_valid_i && p_ready;
  assign pop_o   = issue && phase_q;

  // Low result first: a*cos_a - x*sin_a, then x*cos_x + a*sin_x
  always_comb begin
    m_a = phase_q ? job_i.x_val : job_i.a_val;
    m_b = phase_q ? job_i.x_cos : job_i.a_cos;
    m_c = phase_q ? job_i.a_val : job_i.x_val;
    m_e = phase_q ? job_i.x_sin : job_i.a_sin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= 1'b0;
      p_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (issue) begin
        phase_q <= !phase_q;
      end
      if (p_ready) begin
        p_valid_q <= issue;
      end
      if (o_ready) begin
        o_valid_q <= p_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      p1_q     <= m_a * m_b;
      p2_q     <= m_c * m_e;
      p_sub_q  <= !phase_q;
      p_idx_q  <= phase_q ? job_i.idx_hi : job_i.idx_lo;
      p_last_q <= phase_q;
      p_vend_q <= phase_q && job_i.vend;
    end
  end

  // Round half up at bit 14, then saturate to 16 bits
  always_comb begin
    sum = p_sub_q ? (rpeh_pkg::SumW'(p1_q) - rpeh_pkg::SumW'(p2_q))
                  : (rpeh_pkg::SumW'(p1_q) + rpeh_pkg::SumW'(p2_q));
    rnd = sum + rpeh_pkg::RndBias;
    qv  = rnd[rpeh_pkg::SumW-1:rpeh_pkg::RndShift];
    if (qv > QW'(32767)) begin
      sat = 16'sh7fff;
    end else if (qv < -QW'(32768)) begin
      sat = 16'sh8000;
    end else begin
      sat = qv[rpeh_pkg::ValW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_ready && p_valid_q) begin
      o_value_q <= sat;
      o_index_q <= p_idx_q;
      o_last_q  <= p_last_q;
      o_vend_q  <= p_vend_q;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_value_o = o_value_q;
  assign out_index_o = o_index_q;
  assign out_last_o  = o_last_q;
  assign out_vend_o  = o_vend_q;

  a_vend_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_valid_q && o_vend_q) |-> o_last_q)
    else $error("vector end flagged on a non-final result");

  a_pop_after_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (p_valid_q || $past(issue)))
    else $error("job popped without its low result issued");

endmodule

/* rtl/rotary_position_rotate_half_unit.sv */
// Top level of the rotate-half rotary position embedding unit.
//
// Usage: stream one head vector element per transaction on s_axis, with its
// cosine and sine table entries. The first half_dim elements are stored in an
// on-chip store and give no result. Each element of the second half pairs with
// its stored partner and gives two results on m_axis: index d (tlast low) and
// then index d+half_dim (tlast high); tuser marks the last result of a vector.
// Writing half_dim over cfg_* restarts the vector count; write only when idle.
// A pairing is registered in the front end, waits in the job queue, then
// passes the product stage and the output register; its second result follows
// the first. A second-half element uses the product stage twice, so results
// leave one a cycle while jobs are queued and m_axis_tready stays high.
// A 4-entry job queue lets input continue while the output is stalled; when
// m_axis_tready stays low the queue fills and s_axis_tready drops.
// Reset clears the counter and sets half_dim to 32; the store is not cleared.
module rotary_position_rotate_half_unit #(
  parameter int MAX_HEAD_DIM = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,      // half_dim
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // vector_value, cos_value, sin_value
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // rotated_value, element_index
  output logic        m_axis_tlast_o,   // run_last
  output logic        m_axis_tuser_o    // vector_end
);

  logic                             push, q_full, q_valid, pop;
  rpeh_pkg::job_t                   push_data, q_data;
  logic signed [rpeh_pkg::ValW-1:0] rot_value;
  logic [rpeh_pkg::IdxW-1:0]        rot_index;

  rpeh_front #(
    .MAX_HEAD_DIM(MAX_HEAD_DIM)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .x_val_i     (s_axis_tdata_i[15:0]),
    .x_cos_i     (s_axis_tdata_i[31:16]),
    .x_sin_i     (s_axis_tdata_i[47:32]),
    .push_o      (push),
    .push_data_o (push_data),
    .q_full_i    (q_full)
  );

  rpeh_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .data_o      (q_data)
  );

  rpeh_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (q_data),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_value_o (rot_value),
    .out_index_o (rot_index),
    .out_last_o  (m_axis_tlast_o),
    .out_vend_o  (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {rot_index, rot_value};

endmodule

/* dv/tb_rotary_position_rotate_half_unit.sv */
// Self-checking stream testbench for the rotate-half rotary position embedding unit.
`timescale 1ns / 100ps

module tb_rotary_position_rotate_half_unit;

  localparam int HeadDimMax   = 256;
  localparam int HalfMax      = HeadDimMax / 2;
  localparam int SettleCycles = 16;
  localparam int HoldCycles   = 150;
  localparam int StallLimit   = 2000;
  localparam int ReportMax    = 10;

  typedef struct {
    logic signed [rpeh_pkg::ValW-1:0] val;
    logic signed [rpeh_pkg::ValW-1:0] cs;
    logic signed [rpeh_pkg::ValW-1:0] sn;
  } elem_t;

  typedef struct {
    logic signed [rpeh_pkg::ValW-1:0] value;
    logic [rpeh_pkg::IdxW-1:0]        idx;
    logic                             last;
    logic                             vend;
  } rot_t;

  logic                      clk_i           = 1'b0;
  logic                      rst_ni          = 1'b0;
  logic                      cfg_we_i        = 1'b0;
  logic [rpeh_pkg::CfgW-1:0] cfg_wdata_i     = '0;
  logic                      s_axis_tvalid_i = 1'b0;
  logic                      s_axis_tready_o;
  logic [47:0]               s_axis_tdata_i  = '0;   // vector_value, cos_value, sin_value
  logic                      m_axis_tvalid_o;
  logic                      m_axis_tready_i = 1'b0;
  logic [23:0]               m_axis_tdata_o;         // rotated_value, element_index
  logic                      m_axis_tlast_o;         // run_last
  logic                      m_axis_tuser_o;         // vector_end

  elem_t elem_q[$];
  rot_t  rot_expect_q[$];
  elem_t tx_elem;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_toggle = 1'b0;
  bit hold_seen;
  int hold_left;
  int stall_cycles;

  // Predictor state
  logic [rpeh_pkg::CfgW-1:0]        half_reg   = rpeh_pkg::HalfDimReset;
  int unsigned                      elem_count = 0;
  logic signed [rpeh_pkg::ValW-1:0] store_val[HalfMax];
  logic signed [rpeh_pkg::ValW-1:0] store_cos[HalfMax];
  logic signed [rpeh_pkg::ValW-1:0] store_sin[HalfMax];

  int mismatches      = 0;
  int elems_in        = 0;
  int results_checked = 0;
  int settings_done   = 0;

  rotary_position_rotate_half_unit #(
    .MAX_HEAD_DIM(HeadDimMax)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always #2 clk_i = ~clk_i;

  // Q9.22 sum to Q8.8, round half up, saturate
  function automatic logic [rpeh_pkg::ValW-1:0] round_q88(input longint acc);
    longint q;
    q = (acc + 8192) >>> 14;
    if (q > 32767) q = 32767;
    else if (q < -32768) q = -32768;
    return q[rpeh_pkg::ValW-1:0];
  endfunction

  // Append one result to the tail of the expected list
  function automatic void expect_rot(input rot_t r);
    rot_expect_q.insert(rot_expect_q.size(), r);
  endfunction

  function automatic void rotate_element(input logic [47:0] data);
    logic signed [rpeh_pkg::ValW-1:0] x, c, s, a, a_c, a_s;
    int unsigned h, n, d;
    longint lo, hi;
    rot_t r;
    x = data[15:0];
    c = data[31:16];
    s = data[47:32];
    h = (half_reg == 0) ? 1 : ((half_reg > HalfMax) ? HalfMax : half_reg);
    n = elem_count;
    if (n >= 2 * h) n = 0;
    elems_in++;
    if (n < h) begin
      store_val[n] = x;
      store_cos[n] = c;
      store_sin[n] = s;
      elem_count = n + 1;
    end else begin
      d   = n - h;
      a   = store_val[d];
      a_c = store_cos[d];
      a_s = store_sin[d];
      lo = longint'(a) * longint'(a_c) - longint'(x) * longint'(a_s);
      hi = longint'(x) * longint'(c) + longint'(a) * longint'(s);
      r.value = round_q88(lo);
      r.idx   = rpeh_pkg::IdxW'(d);
      r.last  = 1'b0;
      r.vend  = 1'b0;
      expect_rot(r);
      r.value = round_q88(hi);
      r.idx   = rpeh_pkg::IdxW'(d + h);
      r.last  = 1'b1;
      r.vend  = (n + 1 == 2 * h);
      expect_rot(r);
      elem_count = (n + 1 == 2 * h) ? 0 : n + 1;
    end
  endfunction

  function automatic void check_rotated(input logic [23:0] data, input logic last,
                                        input logic vend);
    rot_t want;
    if (rot_expect_q.size() == 0) begin
      mismatches++;
      if (mismatches <= ReportMax)
        $display("unexpected result: value %0d index %0d last %0b end %0b",
                 $signed(data[15:0]), data[23:16], last, vend);
    end else begin
      want = rot_expect_q.pop_front();
      results_checked++;
      if (data[15:0] !== want.value || data[23:16] !== want.idx ||
          last !== want.last || vend !== want.vend) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display({"mismatch: got value %0d index %0d last %0b end %0b, ",
                    "expected value %0d index %0d last %0b end %0b"},
                   $signed(data[15:0]), data[23:16], last, vend,
                   want.value, want.idx, want.last, want.vend);
      end
    end
  endfunction

  // Driver: hold the offer until accepted, otherwise idle at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else if (!s_axis_tvalid_i || s_axis_tready_o) begin
      if (elem_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        tx_elem = elem_q.pop_front();
        s_axis_tdata_i  <= {tx_elem.sn, tx_elem.cs, tx_elem.val};
        s_axis_tvalid_i <= 1'b1;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus a long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      hold_seen       <= 1'b0;
      hold_left       <= 0;
    end else if (hold_toggle != hold_seen) begin
      hold_seen       <= hold_toggle;
      hold_left       <= HoldCycles;
      m_axis_tready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left       <= hold_left - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Monitor: check results, then track register writes and accepted elements
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i)
        check_rotated(m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);
      if (cfg_we_i) begin
        half_reg   = cfg_wdata_i;
        elem_count = 0;
      end
      if (s_axis_tvalid_i && s_axis_tready_o)
        rotate_element(s_axis_tdata_i);
    end
  end

  // Watchdog: end the run if no transaction moves for too long
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_cycles <= 0;
    end else if ((s_axis_tvalid_i && s_axis_tready_o) ||
                 (m_axis_tvalid_o && m_axis_tready_i) || cfg_we_i) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic queue_elem(input int v, input int c, input int s);
    elem_t e;
    e.val = rpeh_pkg::ValW'(v);
    e.cs  = rpeh_pkg::ValW'(c);
    e.sn  = rpeh_pkg::ValW'(s);
    elem_q.insert(elem_q.size(), e);
  endtask

  function automatic int table_entry();
    if ($urandom_range(9) == 0) return int'($urandom);
    return int'($urandom_range(32768)) - 16384;
  endfunction

  task automatic queue_random(input int count);
    int v;
    for (int i = 0; i < count; i++) begin
      v = int'($urandom);
      if ($urandom_range(7) == 0) begin
        case ($urandom_range(3))
          0: v = 32767;
          1: v = -32768;
          2: v = 0;
          default: v = -1;
        endcase
      end
      queue_elem(v, table_entry(), table_entry());
    end
  endtask

  task automatic write_half(input int half);
    @(posedge clk_i);
    cfg_wdata_i <= rpeh_pkg::CfgW'(half);
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    settings_done++;
  endtask

  // Wait for every element to go in and every result to come out, then settle
  task automatic wait_drained();
    do @(negedge clk_i);
    while (elem_q.size() != 0 || s_axis_tvalid_i || rot_expect_q.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic run_phase(input int half, input int count, input int pause_at,
                           input bit hold_rx, input int tx_idle, input int rx_idle);
    write_half(half);
    @(negedge clk_i);
    tx_idle_pct = tx_idle;
    rx_idle_pct = rx_idle;
    if (hold_rx) hold_toggle = ~hold_toggle;
    if (pause_at > 0) begin
      // stop mid-vector until the pipeline is empty, then carry on
      queue_random(pause_at);
      wait_drained();
      queue_random(count - pause_at);
    end else begin
      queue_random(count);
    end
    wait_drained();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Zero half length acts as one: each pair of elements is a whole vector
    write_half(0);
    @(negedge clk_i);
    tx_idle_pct = 11;
    rx_idle_pct = 68;
    queue_elem(32767, 16384, -16384);
    queue_elem(32767, 16384, 16384);
    queue_elem(-32768, 16384, 16384);
    queue_elem(32767, -16384, 16384);
    queue_elem(1, 8192, 0);
    queue_elem(0, 0, 0);
    queue_elem(-1, 8192, 0);
    queue_elem(0, 0, 0);
    queue_elem(3, 8192, -8192);
    queue_elem(-1, 8192, 0);
    queue_elem(256, -32768, 32767);
    queue_elem(256, 32767, -32768);
    queue_elem(0, -16384, -16384);
    queue_elem(-256, -16384, 16384);
    wait_drained();
    // Partial vector, abandoned by the next register write
    write_half(3);
    @(negedge clk_i);
    queue_random(4);
    wait_drained();

    run_phase(128, 20, 0, 1'b0, 11, 68);
    run_phase(1, 30, 0, 1'b0, 11, 68);
    run_phase(5, 50, 0, 1'b1, 68, 11);
    run_phase(255, 256, 0, 1'b0, 68, 11);
    run_phase(17, 68, 20, 1'b0, 68, 11);
    run_phase(2, 40, 0, 1'b0, 0, 0);
    run_phase(32, 64, 0, 1'b0, 0, 0);

    $display("tb: %0d elements streamed, %0d rotated results checked, %0d half-length writes",
             elems_in, results_checked, settings_done);
    $display("tb: half lengths 0, 1, 2, 3, 5, 17, 32, 128, 255 with stalls on both sides");
    if (mismatches == 0 && rot_expect_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
